// File: rtl/rqs_pkg.sv
package rqs_pkg;

    localparam int QueueDepthDefault = 16;

    localparam logic [1:0] POLICY_FIFO     = 2'd0;
    localparam logic [1:0] POLICY_SHORTEST = 2'd1;
    localparam logic [1:0] POLICY_LOTTERY  = 2'd2;

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] new_pid;
        logic [3:0]  burst_time;
        logic [3:0]  tickets;
        logic [15:0] random_draw;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_pid;
        logic [3:0]  out_burst;
        logic [3:0]  out_tickets;
        logic [4:0]  occupancy;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN_REQ,
        S_SCAN,
        S_MOD,
        S_PICK_REQ,
        S_PICK,
        S_READ_REQ,
        S_READ,
        S_SHIFT_REQ,
        S_SHIFT,
        S_DONE
    } exec_state_t;

endpackage

// File: rtl/rqs_ram.sv
module rqs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/rqs_front.sv
module rqs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rqs_pkg::request_t req,
    input  logic              take,
    output logic              busy,
    output logic              q_valid,
    output rqs_pkg::request_t q_req
);

    // one-entry request queue; zero tickets stored as one
    logic              valid_reg;
    rqs_pkg::request_t req_reg;
    rqs_pkg::request_t req_next;

    always_comb
    begin
        req_next = req;
        if (req.tickets == 4'd0)
        begin
            req_next.tickets = 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (start && !busy)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req_next;
        end
    end

    assign busy    = valid_reg;
    assign q_valid = valid_reg;
    assign q_req   = req_reg;

endmodule

// File: rtl/rqs_back.sv
module rqs_back #(
    parameter int QUEUE_DEPTH = rqs_pkg::QueueDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        policy,
    input  logic              q_valid,
    input  rqs_pkg::request_t q_req,
    output logic              take,
    output logic              res_strobe,
    output rqs_pkg::result_t  res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = CW + 4;

    rqs_pkg::exec_state_t state_reg, state_next;
    rqs_pkg::request_t    cur_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        idx_reg;
    logic [AW-1:0]        sel_reg;
    logic [3:0]           best_reg;
    logic [TW-1:0]        total_reg, sum_reg;
    logic [15:0]          rem_reg;
    logic [4:0]           mbit_reg;
    rqs_pkg::result_t     res_reg;
    logic                 strobe_reg;
    logic                 found_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [23:0]   wr_data, rd_data;

    rqs_ram #(.WIDTH(24), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [CW-1:0] idx_inc;
    logic [TW-1:0] sum_inc;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_try;
    logic          is_full, is_empty;

    assign idx_inc  = idx_reg + CW'(1);
    assign sum_inc  = sum_reg + TW'(rd_data[3:0]);
    assign is_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    // restoring remainder: one bit of the draw a cycle
    assign rem_sh   = {rem_reg, 1'b0};

    always_comb
    begin
        rem_try = 17'(rem_sh | 17'(cur_reg.random_draw[mbit_reg[3:0]]));
        if (rem_try >= 17'(total_reg))
        begin
            rem_try = rem_try - 17'(total_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rqs_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_req.kind == rqs_pkg::KIND_PUSH)
                        state_next = rqs_pkg::S_PUSH;
                    else if (is_empty)
                        state_next = rqs_pkg::S_DONE;
                    else if (policy == rqs_pkg::POLICY_SHORTEST
                             || policy == rqs_pkg::POLICY_LOTTERY)
                        state_next = rqs_pkg::S_SCAN_REQ;
                    else
                        state_next = rqs_pkg::S_READ_REQ;
                end
            end
            rqs_pkg::S_PUSH:      state_next = rqs_pkg::S_DONE;
            rqs_pkg::S_SCAN_REQ:  state_next = rqs_pkg::S_SCAN;
            rqs_pkg::S_SCAN:
            begin
                if (idx_inc == count_reg)
                    state_next = (policy == rqs_pkg::POLICY_LOTTERY) ?
                        rqs_pkg::S_MOD : rqs_pkg::S_READ_REQ;
                else
                    state_next = rqs_pkg::S_SCAN_REQ;
            end
            rqs_pkg::S_MOD:
            begin
                if (mbit_reg == 5'd0)
                    state_next = rqs_pkg::S_PICK_REQ;
            end
            rqs_pkg::S_PICK_REQ:  state_next = rqs_pkg::S_PICK;
            rqs_pkg::S_PICK:
            begin
                if (found_reg || idx_inc == count_reg)
                    state_next = rqs_pkg::S_READ_REQ;
                else
                    state_next = rqs_pkg::S_PICK_REQ;
            end
            rqs_pkg::S_READ_REQ:  state_next = rqs_pkg::S_READ;
            rqs_pkg::S_READ:
            begin
                if (CW'(sel_reg) + CW'(1) >= count_reg)
                    state_next = rqs_pkg::S_DONE;
                else
                    state_next = rqs_pkg::S_SHIFT_REQ;
            end
            rqs_pkg::S_SHIFT_REQ: state_next = rqs_pkg::S_SHIFT;
            rqs_pkg::S_SHIFT:
            begin
                // count_reg already holds the reduced count here
                if (idx_inc >= count_reg)
                    state_next = rqs_pkg::S_DONE;
                else
                    state_next = rqs_pkg::S_SHIFT_REQ;
            end
            rqs_pkg::S_DONE:      state_next = rqs_pkg::S_IDLE;
            default:              state_next = rqs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(count_reg);
        wr_data = {cur_reg.new_pid, cur_reg.burst_time, cur_reg.tickets};
        rd_addr = AW'(idx_reg);
        take    = 1'b0;
        unique case (state_reg)
            rqs_pkg::S_IDLE:
            begin
                take = q_valid;
            end
            rqs_pkg::S_PUSH:
            begin
                wr_en = !is_full;
            end
            rqs_pkg::S_READ_REQ:
            begin
                rd_addr = sel_reg;
            end
            rqs_pkg::S_SHIFT_REQ:
            begin
                rd_addr = AW'(idx_inc);
            end
            rqs_pkg::S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rqs_pkg::S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == rqs_pkg::S_DONE);
            if (state_reg == rqs_pkg::S_PUSH && !is_full)
                count_reg <= count_reg + CW'(1);
            if (state_reg == rqs_pkg::S_READ)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rqs_pkg::S_IDLE:
            begin
                cur_reg   <= q_req;
                idx_reg   <= '0;
                sel_reg   <= '0;
                best_reg  <= 4'hf;
                total_reg <= '0;
                sum_reg   <= '0;
                rem_reg   <= '0;
                mbit_reg  <= 5'd15;
                found_reg <= 1'b0;
                res_reg   <= '0;
                res_reg.occupancy <= 5'(count_reg);
                if (q_req.kind == rqs_pkg::KIND_PUSH)
                    res_reg.status <= rqs_pkg::ST_PUSHED;
                else
                    res_reg.status <= rqs_pkg::ST_EMPTY;
            end
            rqs_pkg::S_PUSH:
            begin
                if (is_full)
                    res_reg.status <= rqs_pkg::ST_FULL;
                else
                    res_reg.occupancy <= 5'(count_reg + CW'(1));
            end
            rqs_pkg::S_SCAN:
            begin
                if (idx_reg == '0 || rd_data[7:4] < best_reg)
                begin
                    best_reg <= rd_data[7:4];
                    sel_reg  <= AW'(idx_reg);
                end
                total_reg <= sum_inc;
                sum_reg   <= sum_inc;
                idx_reg   <= (idx_inc == count_reg) ? '0 : idx_inc;
            end
            rqs_pkg::S_MOD:
            begin
                rem_reg  <= rem_try[15:0];
                mbit_reg <= mbit_reg - 5'd1;
                sum_reg  <= '0;
                sel_reg  <= '0;
            end
            rqs_pkg::S_PICK:
            begin
                if (!found_reg)
                begin
                    sum_reg <= sum_inc;
                    if (sum_inc > TW'(rem_reg))
                    begin
                        found_reg <= 1'b1;
                        sel_reg   <= AW'(idx_reg);
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
            end
            rqs_pkg::S_READ:
            begin
                res_reg.status      <= rqs_pkg::ST_POPPED;
                res_reg.out_pid     <= rd_data[23:8];
                res_reg.out_burst   <= rd_data[7:4];
                res_reg.out_tickets <= rd_data[3:0];
                res_reg.occupancy   <= 5'(count_reg - CW'(1));
                idx_reg             <= CW'(sel_reg);
            end
            rqs_pkg::S_SHIFT:
            begin
                idx_reg <= idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");
    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !take)
        else $error("request taken twice");
    a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> $past(state_reg) == rqs_pkg::S_DONE)
        else $error("result without completion");
    a_popped_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.status != rqs_pkg::ST_POPPED |-> res.out_pid == '0)
        else $error("pid on non-pop result");

endmodule

// File: rtl/ready_queue_scheduler_core.sv
// ready-queue scheduler core
// requests: drive req and pulse start while busy is low; the request is
// taken at that edge. kind selects push or pop of a process record.
// each request gives one result on res for a single cycle, marked by
// res_strobe; the receiver cannot hold it off.
// steps: a push writes the record at the tail; a fifo pop reads the record
// and then moves each record behind it up one slot; a shortest-job pop first
// scans every queued record, and a lottery pop adds a remainder step (one draw
// bit a cycle) and a ticket walk. all work goes through the record ram, one
// registered read a cycle. busy stays high from acceptance until the back end
// takes the request, so one request may wait while another is in progress.
// policy is written over the apb port (byte address 0); the user writes it
// only while idle, which the block itself does not enforce.
// reset empties the queue and sets the policy to fifo; no clearing pass.
module ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = rqs_pkg::QueueDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rqs_pkg::request_t req,
    output logic              res_strobe,
    output rqs_pkg::result_t  res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              take, q_valid;
    rqs_pkg::request_t q_req;
    logic [1:0]        policy_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= rqs_pkg::POLICY_FIFO;
        end
        else if (psel && penable && pwrite && !paddr)
        begin
            policy_reg <= pwdata[1:0];
        end
    end

    assign prdata = paddr ? 32'd0 : {30'd0, policy_reg};

    rqs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .take    (take),
        .busy    (busy),
        .q_valid (q_valid),
        .q_req   (q_req)
    );

    rqs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .policy     (policy_reg),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .take       (take),
        .res_strobe (res_strobe),
        .res        (res)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int Depth = rqs_pkg::QueueDepthDefault;
    localparam int StallLimit = 5000;
    // policy code with no meaning of its own, behaves as fifo
    localparam logic [1:0] PolicyUnused = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    rqs_pkg::request_t req = '0;
    logic              res_strobe;
    rqs_pkg::result_t  res;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic              paddr = 1'b0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    typedef struct {
        rqs_pkg::request_t rq;
        bit                typed;
        rqs_pkg::result_t  want;
    } stim_row_t;

    // queue model, kept in arrival order
    logic [1:0]       sched_policy;
    logic [15:0]      ready_pid[$];
    logic [3:0]       ready_burst[$];
    logic [3:0]       ready_tickets[$];
    rqs_pkg::result_t pending_results[$];
    int               mismatches = 0;
    int               quiet_cycles = 0;

    always #2 clk = ~clk;

    ready_queue_scheduler_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .res_strobe(res_strobe), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    function automatic rqs_pkg::result_t schedule_step(rqs_pkg::request_t r);
        rqs_pkg::result_t o;
        int               sel;
        int               total;
        int               sum;
        int               winner;
        o = '0;
        if (r.kind == rqs_pkg::KIND_PUSH)
        begin
            if (ready_pid.size() >= Depth)
            begin
                o.status = rqs_pkg::ST_FULL;
            end
            else
            begin
                ready_pid.push_back(r.new_pid);
                ready_burst.push_back(r.burst_time);
                ready_tickets.push_back(r.tickets == 4'd0 ? 4'd1 : r.tickets);
                o.status = rqs_pkg::ST_PUSHED;
            end
        end
        else if (ready_pid.size() == 0)
        begin
            o.status = rqs_pkg::ST_EMPTY;
        end
        else
        begin
            sel = 0;
            if (sched_policy == rqs_pkg::POLICY_SHORTEST)
            begin
                for (int i = 1; i < ready_pid.size(); i++)
                    if (ready_burst[i] < ready_burst[sel])
                        sel = i;
            end
            else if (sched_policy == rqs_pkg::POLICY_LOTTERY)
            begin
                total = 0;
                sum = 0;
                foreach (ready_tickets[i])
                    total += ready_tickets[i];
                winner = r.random_draw % total;
                for (int i = 0; i < ready_pid.size(); i++)
                begin
                    sum += ready_tickets[i];
                    if (sum > winner)
                    begin
                        sel = i;
                        break;
                    end
                end
            end
            o.status = rqs_pkg::ST_POPPED;
            o.out_pid = ready_pid[sel];
            o.out_burst = ready_burst[sel];
            o.out_tickets = ready_tickets[sel];
            ready_pid.delete(sel);
            ready_burst.delete(sel);
            ready_tickets.delete(sel);
        end
        o.occupancy = 5'(ready_pid.size());
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        rqs_pkg::result_t want;
        if (rst_n && res_strobe)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", res.status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.status !== want.status)
                    report_mismatch("status", res.status, want.status);
                if (res.out_pid !== want.out_pid)
                    report_mismatch("out_pid", res.out_pid, want.out_pid);
                if (res.out_burst !== want.out_burst)
                    report_mismatch("out_burst", res.out_burst, want.out_burst);
                if (res.out_tickets !== want.out_tickets)
                    report_mismatch("out_tickets", res.out_tickets, want.out_tickets);
                if (res.occupancy !== want.occupancy)
                    report_mismatch("occupancy", res.occupancy, want.occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || res_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == StallLimit)
        begin
            $display("[ready_queue_scheduler_core] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // start stays high straight into the next request when the gap is zero
    task automatic issue_request(rqs_pkg::request_t r, bit typed, rqs_pkg::result_t want);
        rqs_pkg::result_t predicted;
        int               gap;
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!(start && !busy));
        predicted = schedule_step(r);
        pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_policy(logic [1:0] value);
        @(posedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {30'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sched_policy = value;
        @(posedge clk);
    endtask

    stim_row_t directed_rows[8] = '{
        '{'{rqs_pkg::KIND_POP, 16'h0000, 4'h0, 4'h0, 16'h0000}, 1'b1,
          '{rqs_pkg::ST_EMPTY, 16'h0000, 4'h0, 4'h0, 5'd0}},
        '{'{rqs_pkg::KIND_PUSH, 16'hFFFF, 4'hF, 4'hF, 16'hFFFF}, 1'b1,
          '{rqs_pkg::ST_PUSHED, 16'h0000, 4'h0, 4'h0, 5'd1}},
        '{'{rqs_pkg::KIND_PUSH, 16'h0000, 4'h0, 4'h0, 16'h0000}, 1'b1,
          '{rqs_pkg::ST_PUSHED, 16'h0000, 4'h0, 4'h0, 5'd2}},
        '{'{rqs_pkg::KIND_PUSH, 16'h1234, 4'h7, 4'h3, 16'h5A5A}, 1'b0, '0},
        '{'{rqs_pkg::KIND_POP, 16'hA5A5, 4'h5, 4'hA, 16'hFFFF}, 1'b1,
          '{rqs_pkg::ST_POPPED, 16'hFFFF, 4'hF, 4'hF, 5'd2}},
        // zero tickets come back stored as one
        '{'{rqs_pkg::KIND_POP, 16'h0000, 4'h0, 4'h0, 16'h0000}, 1'b1,
          '{rqs_pkg::ST_POPPED, 16'h0000, 4'h0, 4'h1, 5'd1}},
        '{'{rqs_pkg::KIND_POP, 16'hFFFF, 4'hF, 4'hF, 16'h0001}, 1'b0, '0},
        '{'{rqs_pkg::KIND_POP, 16'h0000, 4'h0, 4'h0, 16'h8000}, 1'b1,
          '{rqs_pkg::ST_EMPTY, 16'h0000, 4'h0, 4'h0, 5'd0}}
    };

    logic [1:0] policy_plan[7] = '{rqs_pkg::POLICY_SHORTEST, rqs_pkg::POLICY_LOTTERY,
                                    PolicyUnused, rqs_pkg::POLICY_FIFO,
                                    rqs_pkg::POLICY_LOTTERY, rqs_pkg::POLICY_SHORTEST,
                                    rqs_pkg::POLICY_LOTTERY};

    initial
    begin
        rqs_pkg::request_t r;
        int                push_pct;
        sched_policy = rqs_pkg::POLICY_FIFO;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            issue_request(directed_rows[i].rq, directed_rows[i].typed,
                          directed_rows[i].want);
        foreach (policy_plan[p])
        begin
            write_policy(policy_plan[p]);
            push_pct = 50;
            for (int n = 0; n < 262; n++)
            begin
                // swing between filling and draining so full and empty both occur
                if (n % 32 == 0)
                    push_pct = ($urandom_range(0, 2) == 0) ? 20 :
                               ($urandom_range(0, 1) == 0) ? 50 : 85;
                r.kind = ($urandom_range(0, 99) < push_pct) ? rqs_pkg::KIND_PUSH
                                                             : rqs_pkg::KIND_POP;
                r.new_pid = 16'($urandom_range(0, 65535));
                r.burst_time = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                           : 4'($urandom_range(0, 15));
                r.tickets = 4'($urandom_range(0, 15));
                r.random_draw = 16'($urandom_range(0, 65535));
                issue_request(r, 1'b0, '0);
            end
        end
        @(posedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("[ready_queue_scheduler_core] OK");
        else
            $display("[ready_queue_scheduler_core] ERROR");
        $finish;
    end

endmodule
